>>> hw/rtl/cspp_pkg.sv
package cspp_pkg;

    // Default geometry and reset values
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int STEP_W         = 4;
    localparam logic [STEP_W-1:0] STEP_RESET = 4'd2;
    localparam int START_X        = 960;
    localparam int START_Y        = 540;

    // Command codes
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;
    localparam logic [OP_W-1:0] OP_DIFF = 4'd1;
    localparam logic [OP_W-1:0] OP_SQX  = 4'd2;
    localparam logic [OP_W-1:0] OP_SQY  = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD  = 4'd4;
    localparam logic [OP_W-1:0] OP_SQI  = 4'd5;
    localparam logic [OP_W-1:0] OP_SQS  = 4'd6;
    localparam logic [OP_W-1:0] OP_MULX = 4'd7;
    localparam logic [OP_W-1:0] OP_MULY = 4'd8;
    localparam logic [OP_W-1:0] OP_DVI  = 4'd9;
    localparam logic [OP_W-1:0] OP_DVS  = 4'd10;
    localparam logic [OP_W-1:0] OP_UPX  = 4'd11;
    localparam logic [OP_W-1:0] OP_UPY  = 4'd12;
    localparam logic [OP_W-1:0] OP_OUT  = 4'd13;

    // Sequencing kinds
    localparam int JMP_W = 3;
    localparam logic [JMP_W-1:0] JMP_NEXT   = 3'd0;
    localparam logic [JMP_W-1:0] JMP_ALWAYS = 3'd1;
    localparam logic [JMP_W-1:0] JMP_LOOP   = 3'd2;
    localparam logic [JMP_W-1:0] JMP_NEAR   = 3'd3;
    localparam logic [JMP_W-1:0] JMP_DONE   = 3'd4;

    localparam int PC_W = 4;

    // Program addresses used as jump targets
    localparam logic [PC_W-1:0] PC_DIFF = 4'd0;
    localparam logic [PC_W-1:0] PC_SQS  = 4'd6;
    localparam logic [PC_W-1:0] PC_DVSX = 4'd9;
    localparam logic [PC_W-1:0] PC_DVSY = 4'd13;
    localparam logic [PC_W-1:0] PC_DONE = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [JMP_W-1:0] jmp;
        logic [PC_W-1:0]  tgt;
    } ucode_t;

    // Control store: measure, root, two divisions, re-measure, hand out
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:    w = '{OP_DIFF, JMP_NEXT,   PC_DIFF};
            4'd1:    w = '{OP_SQX,  JMP_NEXT,   PC_DIFF};
            4'd2:    w = '{OP_SQY,  JMP_NEXT,   PC_DIFF};
            4'd3:    w = '{OP_ADD,  JMP_NEXT,   PC_DIFF};
            4'd4:    w = '{OP_NONE, JMP_NEAR,   PC_DONE};
            4'd5:    w = '{OP_SQI,  JMP_NEXT,   PC_DIFF};
            4'd6:    w = '{OP_SQS,  JMP_LOOP,   PC_SQS};
            4'd7:    w = '{OP_MULX, JMP_NEXT,   PC_DIFF};
            4'd8:    w = '{OP_DVI,  JMP_NEXT,   PC_DIFF};
            4'd9:    w = '{OP_DVS,  JMP_LOOP,   PC_DVSX};
            4'd10:   w = '{OP_UPX,  JMP_NEXT,   PC_DIFF};
            4'd11:   w = '{OP_MULY, JMP_NEXT,   PC_DIFF};
            4'd12:   w = '{OP_DVI,  JMP_NEXT,   PC_DIFF};
            4'd13:   w = '{OP_DVS,  JMP_LOOP,   PC_DVSY};
            4'd14:   w = '{OP_UPY,  JMP_ALWAYS, PC_DIFF};
            4'd15:   w = '{OP_OUT,  JMP_DONE,   PC_DONE};
            default: w = '{OP_OUT,  JMP_DONE,   PC_DONE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/csp_in_if.sv
interface csp_in_if #(
    parameter int COORD_BITS = cspp_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;

    modport source (output valid, output command, output target_x, output target_y,
                    input ready);
    modport sink   (input valid, input command, input target_x, input target_y,
                    output ready);
endinterface

>>> hw/rtl/csp_out_if.sv
interface csp_out_if #(
    parameter int POS_BITS = cspp_pkg::COORD_BITS_DEF + cspp_pkg::FRAC_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [POS_BITS-1:0] position_x;
    logic [POS_BITS-1:0] position_y;
    logic                arrived;

    modport source (output valid, output position_x, output position_y, output arrived,
                    input ready);
    modport sink   (input valid, input position_x, input position_y, input arrived,
                    output ready);
endinterface

>>> hw/rtl/constant_speed_point_pursuit_top.sv
// Constant-speed point pursuit.
// item (sink): command 0 loads target_x/target_y as the new goal in whole
// pixels; command 1 is a tick that moves the point step_size pixels along
// the straight line to the goal, unless it is within one pixel already.
// result (source): one beat per item with the position after the item
// (unsigned COORD_BITS.FRAC_BITS) and arrived, set when the point lies
// within one pixel of the goal.
// cfg_we/cfg_wdata write step_size; write it only while the block is idle.
// One item is worked at a time by a microcoded sequencer driving one shared
// multiplier and a one-bit-per-cycle root/divide unit. A set target, or a
// tick within one pixel, ends after measuring; a tick that moves also runs
// the root loop and two divisions, then measures again.
// item.ready is high while no item is being worked, so a new item is taken
// only once the sequencer has finished the last one. The result register
// holds a beat while result.ready is low, and the next item may already be
// accepted, completing once the register is free.
// Reset: position (960,540) saturated to range, goal (0,0), step_size 2,
// result register empty.
module constant_speed_point_pursuit_top #(
    parameter int COORD_BITS = cspp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cspp_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cspp_pkg::STEP_W-1:0]       cfg_wdata,
    csp_in_if.sink                            item,
    csp_out_if.source                         result
);

    localparam int POS_BITS = COORD_BITS + FRAC_BITS;
    localparam int SQ_SHIFT = (POS_BITS > 31) ? (POS_BITS - 31) : 0;
    localparam int MUL_W    = POS_BITS - SQ_SHIFT;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int RW       = MUL_W + 1;
    localparam int QW       = cspp_pkg::STEP_W + FRAC_BITS;
    localparam int CNT_MAX  = (RW > QW) ? RW : QW;
    localparam int CNT_W    = $clog2(CNT_MAX);
    localparam int THR_SH   = 2 * FRAC_BITS - 2 * SQ_SHIFT;

    localparam logic [63:0] POS_MAX64 = (64'd1 << POS_BITS) - 64'd1;
    localparam logic [63:0] SX64 = 64'(cspp_pkg::START_X) << FRAC_BITS;
    localparam logic [63:0] SY64 = 64'(cspp_pkg::START_Y) << FRAC_BITS;
    localparam logic [POS_BITS-1:0] RST_X =
        POS_BITS'((SX64 > POS_MAX64) ? POS_MAX64 : SX64);
    localparam logic [POS_BITS-1:0] RST_Y =
        POS_BITS'((SY64 > POS_MAX64) ? POS_MAX64 : SY64);
    localparam logic [SUM_W-1:0] THR =
        (THR_SH > 0) ? (SUM_W'(1) << THR_SH) : SUM_W'(1);
    localparam logic [SUM_W-1:0] SQ_BIT0 = SUM_W'(1) << (2 * (RW - 1));
    localparam logic [CNT_W-1:0] SQ_CNT0 = CNT_W'(RW - 1);
    localparam logic [CNT_W-1:0] DV_CNT0 = CNT_W'(QW - 1);

    // Architectural state
    logic [POS_BITS-1:0]        posx_reg, posx_next;
    logic [POS_BITS-1:0]        posy_reg, posy_next;
    logic [COORD_BITS-1:0]      goalx_reg, goalx_next;
    logic [COORD_BITS-1:0]      goaly_reg, goaly_next;
    logic [cspp_pkg::STEP_W-1:0] step_reg, step_next;

    // Sequencer
    logic                       busy_reg, busy_next;
    logic                       phase_reg, phase_next;
    logic [cspp_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // Datapath registers
    logic [MUL_W-1:0]           ax_reg, ax_next;
    logic [MUL_W-1:0]           ay_reg, ay_next;
    logic                       sx_reg, sx_next;
    logic                       sy_reg, sy_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [SUM_W-1:0]           sqv_reg, sqv_next;
    logic [SUM_W-1:0]           sqres_reg, sqres_next;
    logic [SUM_W-1:0]           sqbit_reg, sqbit_next;
    logic [RW-1:0]              rem_reg, rem_next;
    logic [QW-1:0]              nq_reg, nq_next;

    // Result register
    logic                       outv_reg, outv_next;
    logic [POS_BITS-1:0]        outx_reg, outx_next;
    logic [POS_BITS-1:0]        outy_reg, outy_next;
    logic                       outa_reg, outa_next;

    cspp_pkg::ucode_t           uw;
    logic                       in_fire;
    logic                       out_fire;
    logic                       slot_free;
    logic                       far;
    logic                       stall;

    logic signed [POS_BITS+1:0] dx;
    logic signed [POS_BITS+1:0] dy;
    logic [POS_BITS+1:0]        magx;
    logic [POS_BITS+1:0]        magy;
    logic [MUL_W-1:0]           mul_a;
    logic [MUL_W-1:0]           mul_b;
    logic [MUL_W-1:0]           stepf;
    logic [SUM_W:0]             sq_trial;
    logic                       sq_ge;
    logic [RW-1:0]              root;
    logic [RW:0]                dv_trial;
    logic                       dv_ge;
    logic [RW:0]                dv_diff;
    logic [PROD_W-1:0]          num_hi;
    logic [POS_BITS-1:0]        up_pos;
    logic                       up_neg;
    logic [POS_BITS-1:0]        up_q;
    logic [POS_BITS:0]          up_sum;
    logic [POS_BITS-1:0]        up_res;

    assign uw        = cspp_pkg::ucode_rom(pc_reg);
    assign in_fire   = item.valid && item.ready;
    assign out_fire  = result.valid && result.ready;
    assign slot_free = !outv_reg || result.ready;
    assign far       = sum_reg > THR;
    assign stall     = busy_reg && (uw.op == cspp_pkg::OP_OUT) && !slot_free;

    assign item.ready        = !busy_reg;
    assign result.valid      = outv_reg;
    assign result.position_x = outx_reg;
    assign result.position_y = outy_reg;
    assign result.arrived    = outa_reg;

    // Difference vector and magnitudes
    assign dx   = $signed({2'b00, goalx_reg, {FRAC_BITS{1'b0}}}) - $signed({2'b00, posx_reg});
    assign dy   = $signed({2'b00, goaly_reg, {FRAC_BITS{1'b0}}}) - $signed({2'b00, posy_reg});
    assign magx = dx[POS_BITS+1] ? (POS_BITS+2)'(-dx) : dx;
    assign magy = dy[POS_BITS+1] ? (POS_BITS+2)'(-dy) : dy;

    // Shared multiplier operand select
    assign stepf = MUL_W'({step_reg, {FRAC_BITS{1'b0}}});
    always_comb
    begin
        case (uw.op)
            cspp_pkg::OP_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            cspp_pkg::OP_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            cspp_pkg::OP_MULX:
            begin
                mul_a = stepf;
                mul_b = ax_reg;
            end
            default:
            begin
                mul_a = stepf;
                mul_b = ay_reg;
            end
        endcase
    end

    // Root step: one result bit per cycle
    assign sq_trial = {1'b0, sqres_reg} + {1'b0, sqbit_reg};
    assign sq_ge    = {1'b0, sqv_reg} >= sq_trial;
    assign root     = sqres_reg[RW-1:0];

    // Restoring division step: one quotient bit per cycle
    assign dv_trial = {rem_reg, nq_reg[QW-1]};
    assign dv_ge    = dv_trial >= {1'b0, root};
    assign dv_diff  = dv_trial - {1'b0, root};
    assign num_hi   = prod_reg >> QW;

    // Saturating position update
    assign up_neg = (uw.op == cspp_pkg::OP_UPX) ? sx_reg : sy_reg;
    assign up_pos = (uw.op == cspp_pkg::OP_UPX) ? posx_reg : posy_reg;
    assign up_q   = POS_BITS'(nq_reg);
    assign up_sum = {1'b0, up_pos} + {1'b0, up_q};
    always_comb
    begin
        if (up_neg)
        begin
            up_res = (up_pos < up_q) ? '0 : (up_pos - up_q);
        end
        else
        begin
            up_res = up_sum[POS_BITS] ? {POS_BITS{1'b1}} : up_sum[POS_BITS-1:0];
        end
    end

    // Datapath and sequencer next state
    always_comb
    begin
        posx_next  = posx_reg;
        posy_next  = posy_reg;
        goalx_next = goalx_reg;
        goaly_next = goaly_reg;
        step_next  = cfg_we ? cfg_wdata : step_reg;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        prod_next  = prod_reg;
        sum_next   = sum_reg;
        sqv_next   = sqv_reg;
        sqres_next = sqres_reg;
        sqbit_next = sqbit_reg;
        rem_next   = rem_reg;
        nq_next    = nq_reg;
        outv_next  = out_fire ? 1'b0 : outv_reg;
        outx_next  = outx_reg;
        outy_next  = outy_reg;
        outa_next  = outa_reg;

        if (in_fire)
        begin
            busy_next = 1'b1;
            pc_next   = cspp_pkg::PC_DIFF;
            if (item.command == cspp_pkg::CMD_SET)
            begin
                goalx_next = item.target_x;
                goaly_next = item.target_y;
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
            end
        end
        else if (busy_reg && !stall)
        begin
            // Datapath operation of this step
            case (uw.op)
                cspp_pkg::OP_DIFF:
                begin
                    ax_next = MUL_W'(magx >> SQ_SHIFT);
                    ay_next = MUL_W'(magy >> SQ_SHIFT);
                    sx_next = dx[POS_BITS+1];
                    sy_next = dy[POS_BITS+1];
                end
                cspp_pkg::OP_SQX:
                begin
                    prod_next = mul_a * mul_b;
                end
                cspp_pkg::OP_SQY:
                begin
                    sum_next  = SUM_W'(prod_reg);
                    prod_next = mul_a * mul_b;
                end
                cspp_pkg::OP_ADD:
                begin
                    sum_next = sum_reg + SUM_W'(prod_reg);
                end
                cspp_pkg::OP_SQI:
                begin
                    sqv_next   = sum_reg;
                    sqres_next = '0;
                    sqbit_next = SQ_BIT0;
                    cnt_next   = SQ_CNT0;
                end
                cspp_pkg::OP_SQS:
                begin
                    if (sq_ge)
                    begin
                        sqv_next   = sqv_reg - sq_trial[SUM_W-1:0];
                        sqres_next = (sqres_reg >> 1) + sqbit_reg;
                    end
                    else
                    begin
                        sqres_next = sqres_reg >> 1;
                    end
                    sqbit_next = sqbit_reg >> 2;
                end
                cspp_pkg::OP_MULX,
                cspp_pkg::OP_MULY:
                begin
                    prod_next = mul_a * mul_b;
                end
                cspp_pkg::OP_DVI:
                begin
                    rem_next = num_hi[RW-1:0];
                    nq_next  = prod_reg[QW-1:0];
                    cnt_next = DV_CNT0;
                end
                cspp_pkg::OP_DVS:
                begin
                    rem_next = dv_ge ? dv_diff[RW-1:0] : dv_trial[RW-1:0];
                    nq_next  = {nq_reg[QW-2:0], dv_ge};
                end
                cspp_pkg::OP_UPX:
                begin
                    posx_next = up_res;
                end
                cspp_pkg::OP_UPY:
                begin
                    posy_next  = up_res;
                    phase_next = 1'b1;
                end
                cspp_pkg::OP_OUT:
                begin
                    outv_next = 1'b1;
                    outx_next = posx_reg;
                    outy_next = posy_reg;
                    outa_next = !far;
                end
                default:
                begin
                end
            endcase

            // Step sequencing
            case (uw.jmp)
                cspp_pkg::JMP_ALWAYS:
                begin
                    pc_next = uw.tgt;
                end
                cspp_pkg::JMP_LOOP:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                        pc_next  = uw.tgt;
                    end
                    else
                    begin
                        pc_next = pc_reg + cspp_pkg::PC_W'(1);
                    end
                end
                cspp_pkg::JMP_NEAR:
                begin
                    if (phase_reg || !far)
                    begin
                        pc_next = uw.tgt;
                    end
                    else
                    begin
                        pc_next = pc_reg + cspp_pkg::PC_W'(1);
                    end
                end
                cspp_pkg::JMP_DONE:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    pc_next = pc_reg + cspp_pkg::PC_W'(1);
                end
            endcase
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            posx_reg  <= RST_X;
            posy_reg  <= RST_Y;
            goalx_reg <= '0;
            goaly_reg <= '0;
            step_reg  <= cspp_pkg::STEP_RESET;
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            pc_reg    <= cspp_pkg::PC_DIFF;
            cnt_reg   <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            posx_reg  <= posx_next;
            posy_reg  <= posy_next;
            goalx_reg <= goalx_next;
            goaly_reg <= goaly_next;
            step_reg  <= step_next;
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            outv_reg  <= outv_next;
        end
    end

    // Working registers and result payload
    always_ff @(posedge clk)
    begin
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        sqv_reg   <= sqv_next;
        sqres_reg <= sqres_next;
        sqbit_reg <= sqbit_next;
        rem_reg   <= rem_next;
        nq_reg    <= nq_next;
        outx_reg  <= outx_next;
        outy_reg  <= outy_next;
        outa_reg  <= outa_next;
    end

endmodule

>>> tb/constant_speed_point_pursuit_top_tb.sv
`timescale 1ns / 1ps

module constant_speed_point_pursuit_top_tb;

    localparam int COORD_W = cspp_pkg::COORD_BITS_DEF;
    localparam int FRAC_W  = cspp_pkg::FRAC_BITS_DEF;
    localparam int POS_W   = COORD_W + FRAC_W;
    localparam int STEP_W  = cspp_pkg::STEP_W;

    localparam longint POS_TOP = (longint'(1) << POS_W) - 1;
    localparam longint NEAR_SQ = longint'(1) << (2 * FRAC_W);

    localparam logic [POS_W-1:0] X0 = POS_W'(cspp_pkg::START_X << FRAC_W);
    localparam logic [POS_W-1:0] Y0 = POS_W'(cspp_pkg::START_Y << FRAC_W);

    localparam int RAND_ITEMS  = 450;
    localparam int CHASE_CAP   = 120;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             arrived;
    } pos_beat_t;

    // Directed stimulus row; the expected beat is only used where known is set
    typedef struct packed {
        logic               wr_step;
        logic [STEP_W-1:0]  step;
        logic               cmd;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic               known;
        logic [POS_W-1:0]   ex;
        logic [POS_W-1:0]   ey;
        logic               earr;
    } dir_row_t;

    localparam int DIR_N = 22;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // far target straight after reset, no move
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'd4095, 12'd0,    1'b1, X0, Y0, 1'b0},
        // target on the point itself
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'd960,  12'd540,  1'b1, X0, Y0, 1'b1},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd4095, 12'd4095, 1'b1, X0, Y0, 1'b1},
        // exactly one pixel away still counts as arrived
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'd961,  12'd540,  1'b1, X0, Y0, 1'b1},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b1, X0, Y0, 1'b1},
        // just over one pixel on the diagonal: moves and overshoots
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'd961,  12'd541,  1'b1, X0, Y0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'd4095, 12'd4095, 1'b0, '0, '0, 1'b0},
        // zero step: no movement
        '{1'b1, 4'd0,  cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b1, 4'd15, cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd4095, 12'd4095, 1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b1, 4'd1,  cspp_pkg::CMD_SET,  12'd0,    12'd4095, 1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'd4095, 12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'd0,    12'd0,    1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'hAAA,  12'h555,  1'b0, '0, '0, 1'b0},
        '{1'b1, 4'd7,  cspp_pkg::CMD_TICK, 12'h555,  12'hAAA,  1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_SET,  12'h555,  12'hAAA,  1'b0, '0, '0, 1'b0},
        '{1'b0, 4'd0,  cspp_pkg::CMD_TICK, 12'hAAA,  12'h555,  1'b0, '0, '0, 1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [STEP_W-1:0]  cfg_wdata;

    csp_in_if  item_if ();
    csp_out_if res_if ();

    constant_speed_point_pursuit_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_if),
        .result    (res_if)
    );

    // Tracker state: position, goal and step as the block should hold them
    logic [POS_W-1:0]   trk_x;
    logic [POS_W-1:0]   trk_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [STEP_W-1:0]  step_now;
    logic               trk_arrived;

    pos_beat_t pending_pos [$];
    int        mismatches;
    int        beats_sent;
    bit        drv_calm;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Integer square root, floor
    function automatic longint root_floor(input longint v);
        longint root;
        longint trial;
        int     b;
        root = 0;
        for (b = 22; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // Goal minus position on one axis, in position units
    function automatic longint goal_off(input logic [COORD_W-1:0] g,
                                        input logic [POS_W-1:0] p);
        longint gv;
        longint pv;
        gv = g;
        pv = p;
        return (gv << FRAC_W) - pv;
    endfunction

    // One axis of a move: step * |d| / r with the sign of d, saturated
    function automatic logic [POS_W-1:0] step_axis(input logic [POS_W-1:0] p,
                                                   input longint d,
                                                   input longint r);
        longint pv;
        longint mag;
        longint delta;
        longint np;
        pv    = p;
        mag   = (d < 0) ? -d : d;
        delta = ((longint'(step_now) << FRAC_W) * mag) / r;
        np    = (d < 0) ? pv - delta : pv + delta;
        if (np < 0)
            return '0;
        if (np > POS_TOP)
            return POS_TOP[POS_W-1:0];
        return np[POS_W-1:0];
    endfunction

    // Position tracker: applies one item and gives the beat it should cause
    task automatic track_item(input logic cmd, input logic [COORD_W-1:0] tx,
                              input logic [COORD_W-1:0] ty, output pos_beat_t res);
        longint dx;
        longint dy;
        longint sq;
        if (cmd == cspp_pkg::CMD_SET)
        begin
            goal_x = tx;
            goal_y = ty;
        end
        else
        begin
            dx = goal_off(goal_x, trk_x);
            dy = goal_off(goal_y, trk_y);
            sq = dx * dx + dy * dy;
            if (sq > NEAR_SQ)
            begin
                trk_x = step_axis(trk_x, dx, root_floor(sq));
                trk_y = step_axis(trk_y, dy, root_floor(sq));
            end
        end
        dx = goal_off(goal_x, trk_x);
        dy = goal_off(goal_y, trk_y);
        trk_arrived = (dx * dx + dy * dy <= NEAR_SQ);
        res = '{trk_x, trk_y, trk_arrived};
    endtask

    // Idle length: mostly short, now and then long
    function automatic int pick_wait();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 16);
        return $urandom_range(17, 120);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 0) ? '0 : '1;
        return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return STEP_W'(1);
        if (r == 2)
            return '1;
        return STEP_W'($urandom_range(0, (1 << STEP_W) - 1));
    endfunction

    // Send one item; called and returns at a falling edge
    task automatic send_item(input logic cmd, input logic [COORD_W-1:0] tx,
                             input logic [COORD_W-1:0] ty,
                             input bit known, input pos_beat_t typed);
        int        gap;
        pos_beat_t want;
        gap = (drv_calm || $urandom_range(0, 1) == 0) ? 0 : pick_wait();
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid    <= 1'b1;
        item_if.command  <= cmd;
        item_if.target_x <= tx;
        item_if.target_y <= ty;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        track_item(cmd, tx, ty, want);
        pending_pos.push_back(known ? typed : want);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(cspp_pkg::CMD_TICK, pick_coord(), pick_coord(), 1'b0, '0);
    endtask

    // Register write once every outstanding beat is back
    task automatic write_step(input logic [STEP_W-1:0] v);
        item_if.valid <= 1'b0;
        while (pending_pos.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
        step_now = v;
    endtask

    task automatic flag_mismatch(input string what, input pos_beat_t want,
                                 input pos_beat_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s) at %0t: want x=%0d y=%0d arr=%0b, got x=%0d y=%0d arr=%0b",
                     what, $realtime, want.x, want.y, want.arrived,
                     got.x, got.y, got.arrived);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        pos_beat_t got;
        pos_beat_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{res_if.position_x, res_if.position_y, res_if.arrived};
            if (pending_pos.size() == 0)
                flag_mismatch("beat with nothing pending", '0, got);
            else
            begin
                want = pending_pos.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.arrived !== want.arrived)
                    flag_mismatch("position beat", want, got);
            end
        end
    end

    // Result side back-pressure, with calm stretches
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left   = 0;
        calm_left    = 0;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 199) == 0)
                    calm_left = $urandom_range(100, 600);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_wait();
            end
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        int       i;
        int       n;
        int       kind;
        dir_row_t row;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        item_if.valid    = 1'b0;
        item_if.command  = cspp_pkg::CMD_SET;
        item_if.target_x = '0;
        item_if.target_y = '0;
        trk_x            = X0;
        trk_y            = Y0;
        goal_x           = '0;
        goal_y           = '0;
        step_now         = cspp_pkg::STEP_RESET;
        trk_arrived      = 1'b0;
        mismatches       = 0;
        beats_sent       = 0;
        drv_calm         = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows
        for (i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            if (row.wr_step)
                write_step(row.step);
            send_item(row.cmd, row.tx, row.ty, row.known, '{row.ex, row.ey, row.earr});
        end

        // Full-speed run into the origin, saturating both axes on the overshoot
        write_step('1);
        send_item(cspp_pkg::CMD_SET, '0, '0, 1'b0, '0);
        n = 0;
        while (!trk_arrived && n < CHASE_CAP)
        begin
            send_tick();
            n++;
        end

        // Random phases: mostly a target followed by ticks, some chases, some noise
        beats_sent = 0;
        while (beats_sent < RAND_ITEMS)
        begin
            drv_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 2) == 0)
                write_step(pick_step());
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                send_item(cspp_pkg::CMD_SET, pick_coord(), pick_coord(), 1'b0, '0);
                repeat ($urandom_range(1, 30)) send_tick();
            end
            else if (kind < 8)
            begin
                if ($urandom_range(0, 1) == 0)
                    write_step('1);
                send_item(cspp_pkg::CMD_SET, ($urandom_range(0, 1) == 0) ? '0 : '1,
                          ($urandom_range(0, 1) == 0) ? '0 : '1, 1'b0, '0);
                n = 0;
                while (!trk_arrived && n < CHASE_CAP)
                begin
                    send_tick();
                    n++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_item(1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                              1'b0, '0);
            end
        end

        // Drain and finish
        item_if.valid <= 1'b0;
        while (pending_pos.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
